// ===== rtl/core/vdm_pkg.sv =====
// ============================================================================
// vdm_pkg
// Shared types, codes and the mode decision table for the drive mode block.
// ============================================================================
`default_nettype none

package vdm_pkg;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_PEDAL_LOW       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEDAL_HIGH      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERCENT_FLOOR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_ON_LEVEL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_OFF_LEVEL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_READY_LIMIT     = 3'd5;

    localparam logic [7:0] RST_PEDAL_LOW       = 8'd10;
    localparam logic [7:0] RST_PEDAL_HIGH      = 8'd200;
    localparam logic [6:0] RST_PERCENT_FLOOR   = 7'd0;
    localparam logic [6:0] RST_BRAKE_ON_LEVEL  = 7'd42;
    localparam logic [6:0] RST_BRAKE_OFF_LEVEL = 7'd30;
    localparam logic [6:0] RST_READY_LIMIT     = 7'd10;

    // Drive modes.
    localparam logic [2:0] MODE_NOT_READY = 3'd0;
    localparam logic [2:0] MODE_NEUTRAL   = 3'd1;
    localparam logic [2:0] MODE_FORWARD   = 3'd2;
    localparam logic [2:0] MODE_REVERSE   = 3'd3;
    localparam logic [2:0] MODE_REGEN     = 3'd4;
    localparam logic [2:0] MODE_CRUISE    = 3'd5;

    // Gear selector codes.
    localparam logic [1:0] GEAR_NEUTRAL = 2'd0;
    localparam logic [1:0] GEAR_FORWARD = 2'd1;
    localparam logic [1:0] GEAR_REVERSE = 2'd2;
    localparam logic [1:0] GEAR_INIT    = 2'd3;

    localparam logic [7:0] REGEN_CURRENT = 8'd100;
    localparam logic [7:0] CURRENT_MAX   = 8'd127;

    // Depth of the queue between the classifier and the executer.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] pedal_low;
        logic [7:0] pedal_high;
        logic [6:0] percent_floor;
        logic [6:0] brake_on_level;
        logic [6:0] brake_off_level;
        logic [6:0] ready_limit;
    } cfg_t;

    // One pedal after classification. When need_div is clear, base is the
    // final percent; otherwise percent = num / den + base.
    typedef struct packed {
        logic        need_div;
        logic [7:0]  base;
        logic [15:0] num;
        logic [7:0]  den;
    } pedal_t;

    typedef struct packed {
        logic       fault_ok;
        logic [1:0] gear;
        logic       cruise_button;
        logic       regen_button;
        logic       regen_ready;
        logic       regen_enabled;
        pedal_t     brake;
        pedal_t     accel;
    } q_item_t;

    typedef struct packed {
        logic        start;
        logic [15:0] num;
        logic [7:0]  den;
    } div_req_t;

    typedef struct packed {
        logic       done;
        logic [7:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic              motor_safe;
        logic              brake_on;
        logic signed [7:0] current_percent;
        logic              velocity_max;
        logic [2:0]        mode;
    } res_t;

    // Mode transition for a healthy tick.
    function automatic logic [2:0] vdm_next_mode(
        input logic [2:0] cur,
        input logic [1:0] gear,
        input logic       braking,
        input logic       cruise,
        input logic       rbtn,
        input logic       rready,
        input logic       ren
    );
        logic [2:0] nxt;
        if (cur == MODE_NOT_READY) begin
            nxt = MODE_NOT_READY;
        end else if (braking) begin
            nxt = (ren && rready) ? MODE_REGEN : MODE_NEUTRAL;
        end else if (ren && rready && rbtn && !cruise) begin
            nxt = MODE_REGEN;
        end else if (cruise && gear[0] && ren) begin
            nxt = MODE_CRUISE;
        end else begin
            case (gear)
                GEAR_FORWARD: nxt = (cur == MODE_REVERSE) ? MODE_NEUTRAL : MODE_FORWARD;
                GEAR_REVERSE: nxt = (cur == MODE_FORWARD) ? MODE_NEUTRAL : MODE_REVERSE;
                GEAR_INIT:    nxt = MODE_NOT_READY;
                default:      nxt = MODE_NEUTRAL;
            endcase
        end
        return nxt;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/vehicle_drive_mode_fsm_top.sv =====
// ============================================================================
// vehicle_drive_mode_fsm_top: the back end finishes one tick before it takes the next;
// both pedals that need a division share the single 8-step divider.
// aresetn (synchronous, active low) restores registers, mode and brake state.
// ============================================================================
`default_nettype none

// Drive mode controller for a vehicle motor drive.
//
// Each input transaction is one control tick. The front end unpacks it and
// classifies both pedals: a pedal at or below pedal_low maps to the floor
// percent, any other at or above pedal_high maps to full scale, and one in between
// carries a product and span that the back end divides. A two-entry queue
// sits between the two halves, so while it has room the input side keeps accepting
// ticks as the back end is busy dividing or its result waits on the output.
//
// The back end owns the single divider, which works out the quotient bit by bit
// for each pedal and then hands it back. The brake pedal is done first, then the
// accelerator. A finished tick then passes combinationally through the
// hysteresis check, the mode decision and the setpoint mapping, and lands in
// the output register once that is empty or being read. The next queued tick
// starts while a result still waits to be taken.
//
// Per tick the back end steps through idle, the brake start, the accelerator
// start and the finish state, with a wait state after each start that needs a
// division. m_tvalid rises from the output register as the finish state commits.
//
// Configuration writes are always accepted and are meant to happen while the
// block is idle. A write to an index beyond the register list is ignored.

module vehicle_drive_mode_fsm_top #(
    parameter int PERCENT_FULL = 100
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    // Input tick stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata, from bit 0: fault_ok[0], gear[2:1], brake_raw[10:3],
    // accel_raw[18:11], cruise_button[19], regen_button[20],
    // regen_ready[21], regen_enabled[22], zero pad[23].
    input  logic [vdm_pkg::IN_TDATA_W-1:0]  s_tdata,

    // Result stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata, from bit 0: mode[2:0], velocity_max[3],
    // current_percent[11:4] (signed), brake_on[12], motor_safe[13],
    // zero pad[15:14].
    output logic [vdm_pkg::OUT_TDATA_W-1:0] m_tdata,

    // Configuration write channel.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [vdm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vdm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import vdm_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    q_item_t front_item;
    q_item_t q_head;
    logic    q_full;
    logic    q_not_empty;
    logic    q_pop;
    logic    s_accept;
    res_t    res;

    // ------------------------------------------------------------------
    // Configuration registers. The channel never stalls.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_PEDAL_LOW:       cfg_next.pedal_low       = cfg_data;
                CFG_PEDAL_HIGH:      cfg_next.pedal_high      = cfg_data;
                CFG_PERCENT_FLOOR:   cfg_next.percent_floor   = cfg_data[6:0];
                CFG_BRAKE_ON_LEVEL:  cfg_next.brake_on_level  = cfg_data[6:0];
                CFG_BRAKE_OFF_LEVEL: cfg_next.brake_off_level = cfg_data[6:0];
                CFG_READY_LIMIT:     cfg_next.ready_limit     = cfg_data[6:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pedal_low       <= RST_PEDAL_LOW;
            cfg_reg.pedal_high      <= RST_PEDAL_HIGH;
            cfg_reg.percent_floor   <= RST_PERCENT_FLOOR;
            cfg_reg.brake_on_level  <= RST_BRAKE_ON_LEVEL;
            cfg_reg.brake_off_level <= RST_BRAKE_OFF_LEVEL;
            cfg_reg.ready_limit     <= RST_READY_LIMIT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // ------------------------------------------------------------------
    // Front end: classification straight into the queue.
    // ------------------------------------------------------------------
    assign s_tready = !q_full;
    assign s_accept = s_tvalid && s_tready;

    vdm_front #(
        .PERCENT_FULL (PERCENT_FULL)
    ) u_front (
        .tdata (s_tdata),
        .cfg   (cfg_reg),
        .item  (front_item)
    );

    vdm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_accept),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_head),
        .not_empty (q_not_empty)
    );

    // ------------------------------------------------------------------
    // Back end: divisions, mode decision and the output register.
    // ------------------------------------------------------------------
    vdm_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_item      (q_head),
        .q_pop       (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_res     (res)
    );

    assign m_tdata = {2'b00, res.motor_safe, res.brake_on, res.current_percent,
                      res.velocity_max, res.mode};

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // A faulted tick can only leave the block not ready or neutral.
    a_fault_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !res.motor_safe) |->
            (res.mode == MODE_NOT_READY || res.mode == MODE_NEUTRAL))
        else $error("faulted tick left in a driving mode");

    // Regeneration runs at zero velocity and the fixed regen current.
    a_regen_setpoint: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res.mode == MODE_REGEN) |->
            (!res.velocity_max && res.current_percent == REGEN_CURRENT))
        else $error("regen setpoint mismatch");

    // Forward never asks for negative current; reverse never for positive.
    a_current_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (res.mode == MODE_FORWARD || res.mode == MODE_REVERSE)) |->
            (res.velocity_max &&
             ((res.mode == MODE_FORWARD) ? !res.current_percent[7]
                                         : (res.current_percent[7] ||
                                            res.current_percent == 8'sd0))))
        else $error("current setpoint sign does not match the direction");

    // Idle modes give no velocity and no current.
    a_idle_setpoint: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (res.mode == MODE_NOT_READY || res.mode == MODE_NEUTRAL)) |->
            (!res.velocity_max && res.current_percent == 8'sd0))
        else $error("idle mode drives a setpoint");

endmodule

`default_nettype wire

// ===== rtl/core/vdm_front.sv =====
// ============================================================================
// vdm_front
// Unpacks an input transaction and classifies both pedals for the executer.
// ============================================================================
`default_nettype none

module vdm_front #(
    parameter int PERCENT_FULL = 100
) (
    input  logic [vdm_pkg::IN_TDATA_W-1:0] tdata,
    input  vdm_pkg::cfg_t                  cfg,
    output vdm_pkg::q_item_t               item
);
    import vdm_pkg::*;

    // Clamped pedals resolve here; pedals inside the range carry the
    // product and span for the divider.
    function automatic pedal_t map_pedal(input logic [7:0] raw, input cfg_t c);
        logic [7:0] full;
        logic [7:0] flr;
        logic [7:0] hi;
        pedal_t     p;
        full = 8'(PERCENT_FULL);
        flr  = ({1'b0, c.percent_floor} > full) ? full : {1'b0, c.percent_floor};
        hi   = (c.pedal_low >= c.pedal_high) ? c.pedal_low : c.pedal_high;
        p.need_div = 1'b0;
        p.base     = flr;
        p.num      = '0;
        p.den      = 8'd1;
        if (raw <= c.pedal_low) begin
            p.base = flr;
        end else if (raw >= hi) begin
            p.base = full;
        end else begin
            p.need_div = 1'b1;
            p.num      = {8'd0, raw - c.pedal_low} * {8'd0, full - flr};
            p.den      = hi - c.pedal_low;
        end
        return p;
    endfunction

    always_comb begin
        item.fault_ok      = tdata[0];
        item.gear          = tdata[2:1];
        item.brake         = map_pedal(tdata[10:3], cfg);
        item.accel         = map_pedal(tdata[18:11], cfg);
        item.cruise_button = tdata[19];
        item.regen_button  = tdata[20];
        item.regen_ready   = tdata[21];
        item.regen_enabled = tdata[22];
    end

endmodule

`default_nettype wire

// ===== rtl/core/vdm_queue.sv =====
// ============================================================================
// vdm_queue
// Short first-in first-out queue of classified items.
// ============================================================================
`default_nettype none

module vdm_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  vdm_pkg::q_item_t push_item,
    output logic             full,
    input  logic             pop,
    output vdm_pkg::q_item_t pop_item,
    output logic             not_empty
);
    import vdm_pkg::*;

    q_item_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_item  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/vdm_div.sv =====
// ============================================================================
// vdm_div
// Radix-2 restoring divider for a quotient known to fit in eight bits.
// ============================================================================
`default_nettype none

module vdm_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  vdm_pkg::div_req_t req,
    output vdm_pkg::div_rsp_t rsp
);
    import vdm_pkg::*;

    // The caller guarantees num[15:8] < den, so eight steps suffice and the
    // partial remainder always fits in eight bits.
    logic [7:0] rem_reg, rem_next;
    logic [7:0] low_reg, low_next;
    logic [7:0] den_reg, den_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       busy_reg, busy_next;
    logic       done_reg, done_next;
    logic [8:0] trial;
    logic [8:0] diff;
    logic       fits;

    assign trial = {rem_reg, low_reg[7]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = req.num[15:8];
            low_next  = req.num[7:0];
            den_next  = req.den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? diff[7:0] : trial[7:0];
            low_next = {low_reg[6:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == 3'd7) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        den_reg <= den_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = low_reg;

endmodule

`default_nettype wire

// ===== rtl/core/vdm_back.sv =====
// ============================================================================
// vdm_back
// Executes one queued item: pedal divisions, mode decision, result register.
// ============================================================================
`default_nettype none

module vdm_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  vdm_pkg::cfg_t    cfg,
    input  logic             q_not_empty,
    input  vdm_pkg::q_item_t q_item,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output vdm_pkg::res_t    out_res
);
    import vdm_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_BRK_GO   = 3'd1;
    localparam logic [2:0] ST_BRK_WAIT = 3'd2;
    localparam logic [2:0] ST_ACC_GO   = 3'd3;
    localparam logic [2:0] ST_ACC_WAIT = 3'd4;
    localparam logic [2:0] ST_FINISH   = 3'd5;

    logic [2:0] state_reg, state_next;
    q_item_t    item_reg, item_next;
    logic [7:0] brake_pct_reg, brake_pct_next;
    logic [7:0] accel_pct_reg, accel_pct_next;
    logic [2:0] drive_mode_reg, drive_mode_next;
    logic       brake_latched_reg, brake_latched_next;
    logic       out_valid_reg, out_valid_next;
    res_t       res_reg, res_next;

    div_req_t   div_req;
    div_rsp_t   div_rsp;

    // Decision signals for the finishing cycle.
    logic [6:0] brk_thr;
    logic       brk_det;
    logic       brk_new;
    logic [2:0] mode_sel;
    logic [2:0] mode_fin;
    logic [7:0] acc_mag;
    logic       vel;
    logic [7:0] cur;
    logic       commit;

    vdm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        brk_thr = brake_latched_reg ? cfg.brake_off_level : cfg.brake_on_level;
        brk_det = (brake_pct_reg >= {1'b0, brk_thr});
        if (item_reg.fault_ok) begin
            brk_new  = brk_det;
            mode_sel = vdm_next_mode(drive_mode_reg, item_reg.gear, brk_det,
                                     item_reg.cruise_button, item_reg.regen_button,
                                     item_reg.regen_ready, item_reg.regen_enabled);
        end else begin
            brk_new  = brake_latched_reg;
            mode_sel = MODE_NOT_READY;
        end
        acc_mag  = (accel_pct_reg > CURRENT_MAX) ? CURRENT_MAX : accel_pct_reg;
        vel      = 1'b0;
        cur      = 8'd0;
        mode_fin = mode_sel;
        case (mode_sel)
            MODE_FORWARD: begin
                vel = 1'b1;
                cur = acc_mag;
            end
            MODE_REVERSE: begin
                vel = 1'b1;
                cur = 8'd0 - acc_mag;
            end
            MODE_CRUISE: begin
                vel = 1'b1;
                cur = acc_mag;
            end
            MODE_REGEN: begin
                cur = REGEN_CURRENT;
            end
            MODE_NOT_READY: begin
                if (accel_pct_reg < {1'b0, cfg.ready_limit}) begin
                    mode_fin = MODE_NEUTRAL;
                end
            end
            default: begin
                mode_fin = MODE_NEUTRAL;
            end
        endcase
    end

    always_comb begin
        state_next         = state_reg;
        item_next          = item_reg;
        brake_pct_next     = brake_pct_reg;
        accel_pct_next     = accel_pct_reg;
        drive_mode_next    = drive_mode_reg;
        brake_latched_next = brake_latched_reg;
        res_next           = res_reg;
        q_pop              = 1'b0;
        commit             = 1'b0;
        div_req.start      = 1'b0;
        div_req.num        = item_reg.brake.num;
        div_req.den        = item_reg.brake.den;
        if (state_reg == ST_ACC_GO) begin
            div_req.num = item_reg.accel.num;
            div_req.den = item_reg.accel.den;
        end

        case (state_reg)
            ST_IDLE: begin
                if (q_not_empty) begin
                    q_pop      = 1'b1;
                    item_next  = q_item;
                    state_next = ST_BRK_GO;
                end
            end
            ST_BRK_GO: begin
                if (item_reg.brake.need_div) begin
                    div_req.start = 1'b1;
                    state_next    = ST_BRK_WAIT;
                end else begin
                    brake_pct_next = item_reg.brake.base;
                    state_next     = ST_ACC_GO;
                end
            end
            ST_BRK_WAIT: begin
                if (div_rsp.done) begin
                    brake_pct_next = div_rsp.quotient + item_reg.brake.base;
                    state_next     = ST_ACC_GO;
                end
            end
            ST_ACC_GO: begin
                if (item_reg.accel.need_div) begin
                    div_req.start = 1'b1;
                    state_next    = ST_ACC_WAIT;
                end else begin
                    accel_pct_next = item_reg.accel.base;
                    state_next     = ST_FINISH;
                end
            end
            ST_ACC_WAIT: begin
                if (div_rsp.done) begin
                    accel_pct_next = div_rsp.quotient + item_reg.accel.base;
                    state_next     = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!out_valid_reg || out_ready) begin
                    commit                   = 1'b1;
                    drive_mode_next          = mode_fin;
                    brake_latched_next       = brk_new;
                    res_next.mode            = mode_fin;
                    res_next.velocity_max    = vel;
                    res_next.current_percent = cur;
                    res_next.brake_on        = brk_new;
                    res_next.motor_safe      = item_reg.fault_ok;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (commit) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            drive_mode_reg    <= MODE_NOT_READY;
            brake_latched_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            state_reg         <= state_next;
            drive_mode_reg    <= drive_mode_next;
            brake_latched_reg <= brake_latched_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg      <= item_next;
        brake_pct_reg <= brake_pct_next;
        accel_pct_reg <= accel_pct_next;
        res_reg       <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

// ===== sim/tb_vehicle_drive_mode_fsm_top.sv =====
// ============================================================================
// tb_vehicle_drive_mode_fsm_top
// Self-checking bench for the drive mode controller. A queue of control ticks
// feeds a clocked driver, and a clocked monitor checks every result against a
// tick-by-tick prediction of the mode, setpoints and brake state. The run
// steps through several register settings, the extremes among them.
// ============================================================================
`timescale 1ns / 1ps

module tb_vehicle_drive_mode_fsm_top;

    import vdm_pkg::*;

    localparam int PCT_FULL       = 100;
    localparam int LONG_STALL     = 400;   // receiver hold-off that fills the block
    localparam int STALL_AT_A     = 150;   // result counts that trigger the hold-off
    localparam int STALL_AT_B     = 800;
    localparam int SETTLE_CYCLES  = 30;    // beyond the worst-case latency
    localparam int WATCHDOG_LIMIT = 4000;  // cycles without any transaction
    localparam int RANDOM_TICKS   = 175;   // random ticks per register setting
    localparam int NUM_SETTINGS   = 7;

    // An index past the end of the register list; the block ignores it.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct packed {
        logic [2:0]        mode;
        logic              velocity_max;
        logic signed [7:0] current_percent;
        logic              brake_on;
        logic              motor_safe;
    } tick_result_t;

    // ------------------------------------------------------------------------
    // Clock, reset and the ports of the block. Every input starts known.
    // ------------------------------------------------------------------------
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    vehicle_drive_mode_fsm_top #(
        .PERCENT_FULL (PCT_FULL)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Shadow copy of the registers and the controller state. The registers
    // change only when a configuration transaction completes, which happens
    // only while the block is idle.
    // ------------------------------------------------------------------------
    logic [7:0] shadow_low;
    logic [7:0] shadow_high;
    logic [6:0] shadow_floor;
    logic [6:0] shadow_on;
    logic [6:0] shadow_off;
    logic [6:0] shadow_ready;
    logic [2:0] shadow_mode;
    logic       shadow_braking;

    logic [IN_TDATA_W-1:0] pending_ticks[$];
    tick_result_t          expected_results[$];

    int n_ticks    = 0;
    int n_results  = 0;
    int n_settings = 0;
    int n_errors   = 0;

    // Gap and burst state of the sender and receiver.
    int tx_gap   = 0;
    int tx_burst = 0;
    int rx_hold  = 0;
    int rx_burst = 0;
    int idle_cycles = 0;
    logic [1:0] run_gear = GEAR_NEUTRAL;

    // Raw pedal byte to integer percent: clamped at both ends of the pedal
    // range, linear and truncating in between. An inverted or empty range
    // collapses to a step at pedal_low.
    function automatic int pedal_to_percent(input logic [7:0] raw);
        int lo, hi, flr;
        lo  = shadow_low;
        hi  = shadow_high;
        flr = (shadow_floor > PCT_FULL) ? PCT_FULL : shadow_floor;
        if (lo >= hi) hi = lo;
        if (raw <= lo) return flr;
        if (raw >= hi) return PCT_FULL;
        return ((raw - lo) * (PCT_FULL - flr)) / (hi - lo) + flr;
    endfunction

    // Mode decision for a healthy tick. A forward/reverse swap always lands
    // in neutral first, and cruise only looks at the low bit of the gear.
    function automatic logic [2:0] mode_after(
        input logic [2:0] cur,
        input logic [1:0] gear,
        input logic       braking,
        input logic       cruise,
        input logic       rbtn,
        input logic       rready,
        input logic       ren
    );
        logic regen_ok;
        regen_ok = ren && rready;
        if (cur == MODE_NOT_READY) return MODE_NOT_READY;
        if (braking) return regen_ok ? MODE_REGEN : MODE_NEUTRAL;
        if (regen_ok && rbtn && !cruise) return MODE_REGEN;
        if (cruise && ren && gear[0]) return MODE_CRUISE;
        case (gear)
            GEAR_FORWARD: return (cur == MODE_REVERSE) ? MODE_NEUTRAL : MODE_FORWARD;
            GEAR_REVERSE: return (cur == MODE_FORWARD) ? MODE_NEUTRAL : MODE_REVERSE;
            GEAR_INIT:    return MODE_NOT_READY;
            default:      return MODE_NEUTRAL;
        endcase
    endfunction

    // Advances the shadow state by one accepted tick and queues its result.
    task automatic predict_tick(input logic [IN_TDATA_W-1:0] d);
        logic         fault_ok;
        logic [1:0]   gear;
        int           brake_pct, accel_pct, thr, cur;
        logic [2:0]   nxt;
        logic         vel;
        tick_result_t r;
        fault_ok  = d[0];
        gear      = d[2:1];
        brake_pct = pedal_to_percent(d[10:3]);
        accel_pct = pedal_to_percent(d[18:11]);
        if (fault_ok) begin
            thr = shadow_braking ? shadow_off : shadow_on;
            shadow_braking = (brake_pct >= thr);
            nxt = mode_after(shadow_mode, gear, shadow_braking, d[19], d[20], d[21], d[22]);
        end else begin
            // A fault forces not ready and leaves the brake latch untouched.
            nxt = MODE_NOT_READY;
        end
        vel = 1'b0;
        cur = 0;
        case (nxt)
            MODE_FORWARD: begin vel = 1'b1; cur = accel_pct; end
            MODE_REVERSE: begin vel = 1'b1; cur = -accel_pct; end
            MODE_CRUISE:  begin vel = 1'b1; cur = accel_pct; end
            MODE_REGEN:   cur = REGEN_CURRENT;
            MODE_NOT_READY: begin
                if (accel_pct < shadow_ready) nxt = MODE_NEUTRAL;
            end
            default:      nxt = MODE_NEUTRAL;
        endcase
        if (cur > int'(CURRENT_MAX)) cur = CURRENT_MAX;
        if (cur < -int'(CURRENT_MAX)) cur = -int'(CURRENT_MAX);
        shadow_mode = nxt;
        r.mode            = nxt;
        r.velocity_max    = vel;
        r.current_percent = cur[7:0];
        r.brake_on        = shadow_braking;
        r.motor_safe      = fault_ok;
        expected_results.push_back(r);
    endtask

    function automatic logic [IN_TDATA_W-1:0] make_tick(
        input logic       fault_ok,
        input logic [1:0] gear,
        input logic [7:0] brake_raw,
        input logic [7:0] accel_raw,
        input logic       cruise,
        input logic       rbtn,
        input logic       rready,
        input logic       ren
    );
        return {1'b0, ren, rready, rbtn, cruise, accel_raw, brake_raw, gear, fault_ok};
    endfunction

    // Pedal bytes lean on the clamp points of the current setting.
    function automatic logic [7:0] pick_pedal();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return shadow_low;
            3:       return shadow_low + 8'd1;
            4:       return shadow_high;
            5:       return shadow_high - 8'd1;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly healthy ticks with the gear held over runs, so that the mode
    // machine gets past not ready and into its driving states. The rest is
    // raw noise.
    function automatic logic [IN_TDATA_W-1:0] random_tick();
        logic [31:0] noise;
        int          g;
        if ($urandom_range(0, 99) < 8) begin
            noise = $urandom();
            return {1'b0, noise[IN_TDATA_W-2:0]};
        end
        if ($urandom_range(0, 7) == 0) begin
            g = $urandom_range(0, 9);
            run_gear = (g < 2) ? GEAR_NEUTRAL : (g < 6) ? GEAR_FORWARD :
                       (g < 9) ? GEAR_REVERSE : GEAR_INIT;
        end
        return make_tick($urandom_range(0, 19) != 0, run_gear,
                         ($urandom_range(0, 4) < 3) ? 8'($urandom_range(0, shadow_low))
                                                    : pick_pedal(),
                         ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, shadow_low))
                                                     : pick_pedal(),
                         $urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0,
                         $urandom_range(0, 1) == 1, $urandom_range(0, 2) != 0);
    endfunction

    // Idle length after a sender transaction: mostly none or short, a few
    // long, and now and then a burst of back-to-back ticks.
    function automatic int pick_tx_gap();
        int r;
        if (tx_burst > 0) begin
            tx_burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)  tx_burst = $urandom_range(30, 80);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_field(input string name, input int expv, input int actv);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
        n_errors++;
    endtask

    // ------------------------------------------------------------------------
    // Driver: presents queued ticks and predicts each one as its transaction
    // completes. s_tdata and s_tvalid only change when no tick is held.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap   <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_tick(s_tdata);
                n_ticks++;
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap   <= tx_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_ticks.size() > 0) begin
                    s_tdata  <= pending_ticks.pop_front();
                    s_tvalid <= 1'b1;
                    tx_gap   <= pick_tx_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each result transaction against the oldest prediction
    // and drives m_tready. Twice in the run it keeps m_tready low for LONG_STALL,
    // long enough for the block to fill and stall its input.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        tick_result_t want;
        int           r;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_hold  <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_results++;
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing expected, actual tdata 0x%04h",
                             $time, m_tdata);
                    n_errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[2:0] != want.mode)
                        report_field("mode", want.mode, m_tdata[2:0]);
                    if (m_tdata[3] != want.velocity_max)
                        report_field("velocity_max", want.velocity_max, m_tdata[3]);
                    if (m_tdata[11:4] != want.current_percent)
                        report_field("current_percent", want.current_percent,
                                     $signed(m_tdata[11:4]));
                    if (m_tdata[12] != want.brake_on)
                        report_field("brake_on", want.brake_on, m_tdata[12]);
                    if (m_tdata[13] != want.motor_safe)
                        report_field("motor_safe", want.motor_safe, m_tdata[13]);
                    if (m_tdata[15:14] != 2'b00)
                        report_field("tdata pad", 0, m_tdata[15:14]);
                end
            end
            if (m_tvalid && m_tready && (n_results == STALL_AT_A || n_results == STALL_AT_B)) begin
                rx_hold  <= LONG_STALL;
                m_tready <= 1'b0;
            end else if (rx_hold > 0) begin
                rx_hold  <= rx_hold - 1;
                m_tready <= 1'b0;
            end else if (rx_burst > 0) begin
                rx_burst <= rx_burst - 1;
                m_tready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    rx_burst <= $urandom_range(40, 120);
                    m_tready <= 1'b1;
                end else if (r < 60) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    rx_hold  <= (r < 85) ? $urandom_range(0, 2) :
                                (r < 97) ? $urandom_range(3, 14) : $urandom_range(20, 80);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: a run of cycles with no transaction on any channel means the
    // block has hung.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles, %0d results still due",
                         $time, WATCHDOG_LIMIT, expected_results.size());
                $display("CHECKS FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Configuration writes and the phase sequence.
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_PEDAL_LOW:       shadow_low   = value;
            CFG_PEDAL_HIGH:      shadow_high  = value;
            CFG_PERCENT_FLOOR:   shadow_floor = value[6:0];
            CFG_BRAKE_ON_LEVEL:  shadow_on    = value[6:0];
            CFG_BRAKE_OFF_LEVEL: shadow_off   = value[6:0];
            CFG_READY_LIMIT:     shadow_ready = value[6:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input logic [7:0] lo, input logic [7:0] hi,
                                 input logic [6:0] flr, input logic [6:0] on_lvl,
                                 input logic [6:0] off_lvl, input logic [6:0] rdy);
        write_reg(CFG_PEDAL_LOW, lo);
        write_reg(CFG_PEDAL_HIGH, hi);
        write_reg(CFG_PERCENT_FLOOR, {1'b0, flr});
        write_reg(CFG_BRAKE_ON_LEVEL, {1'b0, on_lvl});
        write_reg(CFG_BRAKE_OFF_LEVEL, {1'b0, off_lvl});
        write_reg(CFG_READY_LIMIT, {1'b0, rdy});
        n_settings++;
    endtask

    // Every tick yields one result, so once the queues are empty and the
    // sender is quiet the block is idle; the settle time covers latency.
    task automatic wait_idle();
        while (pending_ticks.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        shadow_low     = RST_PEDAL_LOW;
        shadow_high    = RST_PEDAL_HIGH;
        shadow_floor   = RST_PERCENT_FLOOR;
        shadow_on      = RST_BRAKE_ON_LEVEL;
        shadow_off     = RST_BRAKE_OFF_LEVEL;
        shadow_ready   = RST_READY_LIMIT;
        shadow_mode    = MODE_NOT_READY;
        shadow_braking = 1'b0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // A write past the register list must change nothing.
        write_reg(CFG_UNUSED, 8'hA5);

        // Directed ticks at the reset setting. A brake byte of 77 gives 35
        // percent, between the release and engage levels.
        pending_ticks.push_back(make_tick(0, GEAR_NEUTRAL, 8'h00, 8'h00, 0, 0, 0, 0));
        pending_ticks.push_back(make_tick(1, GEAR_FORWARD, 8'h00, 8'hFF, 0, 0, 0, 0));
        pending_ticks.push_back(make_tick(1, GEAR_FORWARD, 8'h00, 8'd100, 0, 0, 0, 0));
        pending_ticks.push_back(make_tick(1, GEAR_REVERSE, 8'h00, 8'd100, 0, 0, 0, 0));
        pending_ticks.push_back(make_tick(1, GEAR_REVERSE, 8'h00, 8'hFF, 0, 0, 0, 0));
        pending_ticks.push_back(make_tick(1, GEAR_FORWARD, 8'h00, 8'd50, 0, 0, 0, 0));
        pending_ticks.push_back(make_tick(1, GEAR_FORWARD, 8'h00, 8'd50, 0, 0, 0, 0));
        pending_ticks.push_back(make_tick(1, GEAR_FORWARD, 8'hFF, 8'd50, 0, 0, 1, 1));
        pending_ticks.push_back(make_tick(1, GEAR_FORWARD, 8'd77, 8'd50, 0, 0, 0, 0));
        pending_ticks.push_back(make_tick(1, GEAR_FORWARD, 8'd77, 8'd50, 0, 0, 0, 0));
        pending_ticks.push_back(make_tick(1, GEAR_FORWARD, 8'h00, 8'd120, 1, 0, 0, 1));
        pending_ticks.push_back(make_tick(1, GEAR_INIT, 8'h00, 8'd120, 1, 0, 0, 1));
        pending_ticks.push_back(make_tick(1, GEAR_INIT, 8'h00, 8'hFF, 0, 0, 0, 0));
        pending_ticks.push_back(make_tick(1, GEAR_FORWARD, 8'h00, 8'hFF, 0, 0, 0, 0));
        pending_ticks.push_back(make_tick(1, GEAR_FORWARD, 8'h00, 8'h00, 0, 0, 0, 0));
        pending_ticks.push_back(make_tick(1, GEAR_FORWARD, 8'h00, 8'd30, 0, 1, 1, 1));
        pending_ticks.push_back(make_tick(1, GEAR_FORWARD, 8'h00, 8'd30, 1, 1, 1, 1));
        pending_ticks.push_back(make_tick(1, GEAR_NEUTRAL, 8'h00, 8'd30, 0, 0, 0, 0));
        pending_ticks.push_back(make_tick(1, GEAR_NEUTRAL, 8'hFF, 8'd30, 0, 0, 0, 0));
        pending_ticks.push_back(make_tick(0, GEAR_FORWARD, 8'h00, 8'hFF, 1, 1, 1, 1));
        pending_ticks.push_back(make_tick(1, GEAR_INIT, 8'hFF, 8'hFF, 1, 1, 1, 1));
        pending_ticks.push_back(make_tick(1, GEAR_NEUTRAL, 8'd9, 8'd9, 0, 0, 0, 0));
        pending_ticks.push_back(make_tick(1, GEAR_REVERSE, 8'd11, 8'd199, 0, 0, 1, 0));
        wait_idle();

        // Each phase: one register setting, then a run of random ticks.
        for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
            case (ph)
                0: apply_setting(RST_PEDAL_LOW, RST_PEDAL_HIGH, RST_PERCENT_FLOOR,
                                 RST_BRAKE_ON_LEVEL, RST_BRAKE_OFF_LEVEL, RST_READY_LIMIT);
                // Widest pedal range, extreme hysteresis levels.
                1: apply_setting(8'd0, 8'd255, 7'd0, 7'd100, 7'd0, 7'd100);
                // Inverted range with the floor above full scale.
                2: apply_setting(8'd200, 8'd50, 7'd127, 7'd0, 7'd127, 7'd0);
                // Empty range in mid travel.
                3: apply_setting(8'd128, 8'd128, 7'd50, 7'd60, 7'd40, 7'd55);
                // Everything pinned to the top.
                4: apply_setting(8'd255, 8'd255, 7'd100, 7'd127, 7'd127, 7'd127);
                default: apply_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                       7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                                       7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
            endcase
            for (int i = 0; i < RANDOM_TICKS; i++)
                pending_ticks.push_back(random_tick());
            wait_idle();
        end

        if (expected_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_results.size());
            n_errors++;
        end

        $display("Run covered %0d ticks and %0d checked results over %0d register settings,",
                 n_ticks, n_results, n_settings);
        $display("with directed mode transitions, faults, pedal clamps and two long stalls.");
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
